// ===== sv/pmdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdf_pkg
// Shared widths, defaults and register indexes of the pot median filter.
// ----------------------------------------------------------------------------
package pmdf_pkg;

  localparam int PotW    = 4;
  localparam int CodeW   = 10;
  localparam int TickW   = 32;
  localparam int HoldW   = 24;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;

  localparam int NumPotsDef   = 10;
  localparam int WindowLenDef = 15;

  localparam logic [CodeW-1:0] ChangeThrRst = CodeW'(16);
  localparam logic [CodeW-1:0] RelockThrRst = CodeW'(16);
  localparam logic [HoldW-1:0] HoldTicksRst = HoldW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgChangeThr = 2'd0,
    CfgRelockThr = 2'd1,
    CfgHoldTicks = 2'd2
  } cfg_idx_e;

endpackage

// ===== sv/pmdf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pmdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pmdf_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdf_sorter
// Insertion sorter: one code per cycle, while ins_i is high, enters a sorted register row.
// ----------------------------------------------------------------------------
module pmdf_sorter import pmdf_pkg::*; #(
  parameter int Len = WindowLenDef
) (
  input  logic             clk_i,
  input  logic             init_i,
  input  logic             ins_i,
  input  logic [CodeW-1:0] data_i,
  output logic [CodeW-1:0] median_o
);

  localparam int EntW = CodeW + 1;
  localparam int Mid  = Len / 2;

  // entries carry one extra bit so the empty marker sorts above any code
  logic [EntW-1:0] row_q [Len];
  logic [EntW-1:0] row_d [Len];
  logic [Len-1:0]  gt;
  logic [EntW-1:0] val;

  always_comb begin
    val = {1'b0, data_i};
    for (int i = 0; i < Len; i++) begin
      gt[i] = row_q[i] > val;
    end
    for (int i = 0; i < Len; i++) begin
      if (init_i) begin
        row_d[i] = '1;
      end else if (ins_i && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          row_d[i] = row_q[(i > 0) ? i - 1 : 0];
        end else begin
          row_d[i] = val;
        end
      end else begin
        row_d[i] = row_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Len; i++) begin
      row_q[i] <= row_d[i];
    end
  end

  assign median_o = row_q[Mid][CodeW-1:0];

endmodule

// ===== sv/pot_median_deadband_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_median_deadband_filter
// Per-pot median filter with dead band and lock window over sample memory.
// ----------------------------------------------------------------------------
// One item is processed at a time. For an in-range item the pot's window is
// streamed out of the sample memory one entry per cycle into an insertion
// sorter, then the decide step loads the result and writes the pot record back
// when the sample is taken. A pot number of NUM_POTS or more goes from
// acceptance straight to the decide step and writes neither memory. The next
// item is accepted the cycle after the result is loaded, even while that result
// waits on out_stall_i; the decide step waits as long as an earlier result is
// still held by out_stall_i. After reset a clearing pass over all
// NUM_POTS * WINDOW_LEN sample entries zeroes both memories; items are held off
// during it, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module pot_median_deadband_filter import pmdf_pkg::*; #(
  parameter int NUM_POTS   = NumPotsDef,
  parameter int WINDOW_LEN = WindowLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PotW-1:0]    pot_index_i,
  input  logic [CodeW-1:0]   sample_code_i,
  input  logic [TickW-1:0]   now_tick_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PotW-1:0]    pot_number_o,
  output logic [CodeW-1:0]   held_level_o,
  output logic               moved_o
);

  localparam int WinDepth = NUM_POTS * WINDOW_LEN;
  localparam int WinAw    = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam int PotAw    = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;
  localparam int SlotW    = $clog2(WINDOW_LEN);
  localparam int CntW     = $clog2(WINDOW_LEN + 1);
  localparam int RecW     = TickW + 2 * CodeW;

  typedef enum logic [3:0] {
    StClear  = 4'b0001,
    StIdle   = 4'b0010,
    StRun    = 4'b0100,
    StDecide = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CodeW-1:0] chg_thr_q, relock_thr_q;
  logic [HoldW-1:0] hold_q;

  logic [WinAw-1:0] clr_cnt_q, clr_cnt_d;
  logic [SlotW-1:0] wr_slot_q, wr_slot_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [WinAw-1:0] base_q, base_d;
  logic [PotW-1:0]  pot_q, pot_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [TickW-1:0] now_q, now_d;
  logic             bad_q, bad_d;
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [SlotW-1:0] rd_idx_q, rd_idx_d;

  logic             out_valid_q, out_valid_d;
  logic [PotW-1:0]  out_pot_q, out_pot_d;
  logic [CodeW-1:0] out_lvl_q, out_lvl_d;
  logic             out_moved_q, out_moved_d;

  logic             in_acc, in_range, rd_issue, dec_go, sort_ins;
  logic [SlotW-1:0] slot_next;
  logic             win_we;
  logic [WinAw-1:0] win_waddr, win_raddr;
  logic [CodeW-1:0] win_wdata, win_rdata, ins_val, median;
  logic             rec_we;
  logic [PotAw-1:0] rec_waddr;
  logic [RecW-1:0]  rec_wdata, rec_rdata;

  logic [TickW-1:0] lock_until, lock_until_new;
  logic [CodeW-1:0] lock_level, cur_level, diff_cur, diff_lock;
  logic             take, relock;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign in_range   = int'(pot_index_i) < NUM_POTS;
  assign slot_next  = (wr_slot_q == SlotW'(WINDOW_LEN - 1)) ? '0 : wr_slot_q + 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_thr_q    <= ChangeThrRst;
      relock_thr_q <= RelockThrRst;
      hold_q       <= HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgChangeThr: chg_thr_q    <= cfg_wdata_i[CodeW-1:0];
        CfgRelockThr: relock_thr_q <= cfg_wdata_i[CodeW-1:0];
        CfgHoldTicks: hold_q       <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // decision on the pot record read at acceptance
  assign {lock_until, lock_level, cur_level} = rec_rdata;
  always_comb begin
    diff_cur       = (median >= cur_level) ? median - cur_level : cur_level - median;
    diff_lock      = (median >= lock_level) ? median - lock_level : lock_level - median;
    take           = (diff_cur >= chg_thr_q) || (now_q < lock_until);
    relock         = diff_lock >= relock_thr_q;
    lock_until_new = now_q + TickW'(hold_q);
  end

  assign dec_go   = (state_q == StDecide) && (!out_valid_q || !out_stall_i);
  assign rd_issue = (state_q == StRun) && (rd_cnt_q < CntW'(WINDOW_LEN));
  assign sort_ins = rd_vld_q;
  assign ins_val  = (rd_idx_q == slot_q) ? code_q : win_rdata;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    wr_slot_d   = wr_slot_q;
    slot_d      = slot_q;
    base_d      = base_q;
    pot_d       = pot_q;
    code_d      = code_q;
    now_d       = now_q;
    bad_d       = bad_q;
    rd_cnt_d    = rd_cnt_q;
    rd_vld_d    = rd_issue;
    rd_idx_d    = rd_cnt_q[SlotW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_pot_d   = out_pot_q;
    out_lvl_d   = out_lvl_q;
    out_moved_d = out_moved_q;
    win_we      = 1'b0;
    win_waddr   = base_q + WinAw'(slot_q);
    win_wdata   = code_q;
    win_raddr   = base_q + WinAw'(rd_cnt_q);
    rec_we      = 1'b0;
    rec_waddr   = pot_q[PotAw-1:0];
    rec_wdata   = rec_rdata;

    case (state_q)
      StClear: begin
        win_we    = 1'b1;
        win_waddr = clr_cnt_q;
        win_wdata = '0;
        rec_we    = int'(clr_cnt_q) < NUM_POTS;
        rec_waddr = clr_cnt_q[PotAw-1:0];
        rec_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == WinAw'(WinDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          pot_d    = pot_index_i;
          code_d   = sample_code_i;
          now_d    = now_tick_i;
          bad_d    = !in_range;
          rd_cnt_d = '0;
          base_d   = WinAw'(pot_index_i[PotAw-1:0]) * WinAw'(WINDOW_LEN);
          if (in_range && pot_index_i == '0) begin
            wr_slot_d = slot_next;
            slot_d    = slot_next;
          end else begin
            slot_d    = wr_slot_q;
          end
          state_d = in_range ? StRun : StDecide;
        end
      end
      StRun: begin
        // the new sample goes in on the first cycle; its slot is bypassed on read
        win_we = (rd_cnt_q == '0);
        if (rd_issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (rd_vld_q && rd_idx_q == SlotW'(WINDOW_LEN - 1)) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (dec_go) begin
          out_valid_d = 1'b1;
          out_pot_d   = pot_q;
          if (bad_q) begin
            out_lvl_d   = '0;
            out_moved_d = 1'b0;
          end else begin
            out_lvl_d   = take ? median : cur_level;
            out_moved_d = take;
            rec_we      = take;
            rec_wdata   = relock ? {lock_until_new, median, median}
                                 : {lock_until, lock_level, median};
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      wr_slot_q   <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      wr_slot_q   <= wr_slot_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    base_q      <= base_d;
    pot_q       <= pot_d;
    code_q      <= code_d;
    now_q       <= now_d;
    bad_q       <= bad_d;
    rd_idx_q    <= rd_idx_d;
    out_pot_q   <= out_pot_d;
    out_lvl_q   <= out_lvl_d;
    out_moved_q <= out_moved_d;
  end

  pmdf_ram #(
    .Width (CodeW),
    .Depth (WinDepth)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .re_i    (rd_issue),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  pmdf_ram #(
    .Width (RecW),
    .Depth (NUM_POTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (in_acc),
    .raddr_i (pot_index_i[PotAw-1:0]),
    .rdata_o (rec_rdata)
  );

  pmdf_sorter #(
    .Len (WINDOW_LEN)
  ) u_sorter (
    .clk_i    (clk_i),
    .init_i   (in_acc),
    .ins_i    (sort_ins),
    .data_i   (ins_val),
    .median_o (median)
  );

  assign out_valid_o  = out_valid_q;
  assign pot_number_o = out_pot_q;
  assign held_level_o = out_lvl_q;
  assign moved_o      = out_moved_q;

  // a fresh result only ever comes out of the decide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(state_q == StDecide))
    else $error("result loaded outside decide");

  // the sample memory is only written by the clearing pass or the first run cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_we |-> (state_q == StClear || (state_q == StRun && rd_cnt_q == '0)))
    else $error("unexpected sample memory write");

  // window read data only returns while the window is being streamed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == StRun)
    else $error("window read data outside run");

  // a result waiting on the output is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(held_level_o)
                                      && $stable(pot_number_o) && $stable(moved_o)))
    else $error("pending result overwritten");

endmodule
